[design/pic_pkg.sv]
package pic_pkg;

  // line count and derived widths
  localparam int unsigned NUM_LINES    = 32;
  localparam int unsigned PRIO_ENTRIES = 32;
  localparam int unsigned LINE_IDX_W   = 5;
  localparam int unsigned PRIO_W       = 3;
  localparam int unsigned LIMIT_W      = 4;
  localparam int unsigned TREE_LEVELS  = 5;

  localparam logic [31:0]        LINE_MASK   = 32'hFFFF_FFFF >> (32 - NUM_LINES);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd8;

  // operation codes
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_LINE  = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  // register groups
  localparam logic [1:0] GRP_IRQ   = 2'd0;
  localparam logic [1:0] GRP_FIQ   = 2'd1;
  localparam logic [1:0] GRP_SETUP = 2'd2;
  localparam logic [1:0] GRP_PRIO  = 2'd3;

  // output group registers
  localparam logic [7:0] REG_PEND_MASKED = 8'h00;
  localparam logic [7:0] REG_PEND        = 8'h04;
  localparam logic [7:0] REG_EN_SET      = 8'h08;
  localparam logic [7:0] REG_EN_CLR      = 8'h0C;
  localparam logic [7:0] REG_CURRENT     = 8'h20;
  localparam logic [7:0] REG_ACK         = 8'h24;
  localparam logic [7:0] REG_END         = 8'h28;
  localparam logic [7:0] REG_LIMIT       = 8'h2C;

  // line setup registers
  localparam logic [7:0] REG_POLARITY = 8'h00;
  localparam logic [7:0] REG_STICKY   = 8'h04;
  localparam logic [7:0] REG_SPARE    = 8'h08;

  typedef logic [PRIO_ENTRIES-1:0][PRIO_W-1:0] prio_arr_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [9:0]  reg_addr;
    logic [31:0] write_data;
    logic [4:0]  line_number;
    logic        line_level;
  } pic_req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        bad_access;
    logic        irq_request;
    logic        fiq_request;
  } pic_rsp_t;

  // winner of the priority select
  typedef struct packed {
    logic                  found;
    logic [LINE_IDX_W-1:0] idx;
    logic [PRIO_W-1:0]     prio;
  } sel_t;

endpackage

[design/pic_select.sv]
module pic_select (
  input  logic [31:0]         cand_i,
  input  pic_pkg::prio_arr_t  prio_i,
  input  logic [3:0]          limit_i,
  output pic_pkg::sel_t       sel_o
);
  import pic_pkg::*;

  sel_t lvl [0:TREE_LEVELS][0:PRIO_ENTRIES-1];

  // compare tree, left node wins on equal priority
  always_comb begin
    sel_t a;
    sel_t b;
    for (int l = 0; l <= TREE_LEVELS; l++) begin
      for (int i = 0; i < PRIO_ENTRIES; i++) begin
        lvl[l][i] = '0;
      end
    end
    for (int i = 0; i < PRIO_ENTRIES; i++) begin
      lvl[0][i].found = cand_i[i] && ({1'b0, prio_i[i]} < limit_i);
      lvl[0][i].idx   = LINE_IDX_W'(i);
      lvl[0][i].prio  = prio_i[i];
    end
    for (int l = 0; l < TREE_LEVELS; l++) begin
      for (int j = 0; j < (PRIO_ENTRIES >> (l + 1)); j++) begin
        a = lvl[l][2*j];
        b = lvl[l][2*j+1];
        if (b.found && (!a.found || (b.prio < a.prio))) begin
          lvl[l+1][j] = b;
        end else begin
          lvl[l+1][j] = a;
        end
      end
    end
  end

  assign sel_o = lvl[TREE_LEVELS][0];

endmodule

[design/pic_core.sv]
module pic_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  pic_pkg::pic_req_t req_i,
  output pic_pkg::pic_rsp_t rsp_o
);
  import pic_pkg::*;

  // controller state
  logic [31:0]                      active_q, active_d;
  logic [31:0]                      pol_q, pol_d;
  logic [31:0]                      sticky_q, sticky_d;
  logic [31:0]                      raw_prev_q, raw_prev_d;
  logic [31:0]                      edges_q, edges_d;
  logic [31:0]                      pend_q, pend_d;
  logic [1:0][31:0]                 en_q, en_d;
  logic [1:0][LIMIT_W-1:0]          lim_q, lim_d;
  logic [1:0][LIMIT_W-1:0]          sav_q, sav_d;
  prio_arr_t                        prio_q, prio_d;
  logic [1:0]                       irq_q, irq_d;

  logic [1:0]  grp;
  logic [7:0]  off;
  logic        gsel;
  logic [31:0] edges_pre;
  logic [31:0] rd;
  logic        bad;
  logic        do_eval;
  logic [1:0]  end_clr;
  logic [31:0] raw;
  logic [31:0] edges_eval;
  logic [31:0] pend_eval;
  sel_t        cur_sel [2];
  sel_t        new_sel [2];

  assign grp  = req_i.reg_addr[9:8];
  assign off  = req_i.reg_addr[7:0];
  assign gsel = grp[0];

  // current interrupt on present state for reads, on updated state for requests
  for (genvar g = 0; g < 2; g++) begin : g_sel
    pic_select u_cur (
      .cand_i  (pend_q & en_q[g] & LINE_MASK),
      .prio_i  (prio_q),
      .limit_i (lim_q[g]),
      .sel_o   (cur_sel[g])
    );
    pic_select u_new (
      .cand_i  (pend_eval & en_d[g] & LINE_MASK),
      .prio_i  (prio_d),
      .limit_i (lim_d[g]),
      .sel_o   (new_sel[g])
    );
  end

  // register access and line change decode
  always_comb begin
    active_d  = active_q;
    pol_d     = pol_q;
    sticky_d  = sticky_q;
    en_d      = en_q;
    lim_d     = lim_q;
    sav_d     = sav_q;
    prio_d    = prio_q;
    edges_pre = edges_q;
    rd        = '0;
    bad       = 1'b0;
    do_eval   = 1'b0;
    end_clr   = '0;
    if (fire_i) begin
      case (req_i.op)
        OP_READ: begin
          if (grp == GRP_IRQ || grp == GRP_FIQ) begin
            case (off)
              REG_PEND_MASKED: rd = pend_q & en_q[gsel];
              REG_PEND:        rd = pend_q;
              REG_EN_SET:      rd = en_q[gsel];
              REG_EN_CLR:      rd = en_q[gsel];
              REG_CURRENT:     rd = {27'd0, cur_sel[gsel].idx};
              REG_ACK: begin
                rd          = {27'd0, cur_sel[gsel].idx};
                sav_d[gsel] = lim_q[gsel];
                lim_d[gsel] = {1'b0, cur_sel[gsel].prio};
              end
              REG_END: begin
                rd            = {28'd0, sav_q[gsel]};
                end_clr[gsel] = !cur_sel[gsel].found;
              end
              REG_LIMIT:       rd = {28'd0, lim_q[gsel]};
              default:         bad = 1'b1;
            endcase
          end else if (grp == GRP_SETUP) begin
            case (off)
              REG_POLARITY: rd = pol_q;
              REG_STICKY:   rd = sticky_q;
              REG_SPARE:    rd = '0;
              default:      bad = 1'b1;
            endcase
          end else if (!off[7]) begin
            rd = {29'd0, prio_q[req_i.reg_addr[6:2]]};
          end else begin
            bad = 1'b1;
          end
        end
        OP_WRITE: begin
          if (grp == GRP_IRQ || grp == GRP_FIQ) begin
            case (off)
              REG_PEND: begin
                edges_pre = edges_q & ~req_i.write_data;
                do_eval   = 1'b1;
              end
              REG_EN_SET: begin
                en_d[gsel] = (en_q[gsel] | req_i.write_data) & LINE_MASK;
                do_eval    = 1'b1;
              end
              REG_EN_CLR: begin
                en_d[gsel] = en_q[gsel] & ~req_i.write_data;
                do_eval    = 1'b1;
              end
              REG_LIMIT: begin
                lim_d[gsel] = req_i.write_data[LIMIT_W-1:0];
                do_eval     = 1'b1;
              end
              default: bad = 1'b1;
            endcase
          end else if (grp == GRP_SETUP) begin
            case (off)
              REG_POLARITY: begin
                pol_d   = req_i.write_data & LINE_MASK;
                do_eval = 1'b1;
              end
              REG_STICKY: begin
                sticky_d = req_i.write_data & LINE_MASK;
                do_eval  = 1'b1;
              end
              REG_SPARE: bad = 1'b0;
              default:   bad = 1'b1;
            endcase
          end else if (!off[7]) begin
            prio_d[req_i.reg_addr[6:2]] = req_i.write_data[PRIO_W-1:0];
          end else begin
            bad = 1'b1;
          end
        end
        OP_LINE: begin
          if ({1'b0, req_i.line_number} < 6'(NUM_LINES)) begin
            active_d[req_i.line_number] = req_i.line_level;
          end
          do_eval = 1'b1;
        end
        default: begin
          rd = '0;
        end
      endcase
    end
  end

  // line evaluation on the updated setup
  assign raw        = (active_d ^ ~pol_d) & LINE_MASK;
  assign edges_eval = (edges_pre | (raw & ~raw_prev_q)) & LINE_MASK;
  assign pend_eval  = ((raw & ~sticky_d) | (edges_eval & sticky_d)) & LINE_MASK;

  always_comb begin
    raw_prev_d = raw_prev_q;
    edges_d    = edges_q;
    pend_d     = pend_q;
    if (do_eval) begin
      raw_prev_d = raw;
      edges_d    = edges_eval;
      pend_d     = pend_eval;
    end
    for (int g = 0; g < 2; g++) begin
      irq_d[g] = (irq_q[g] & ~end_clr[g]) | (do_eval & new_sel[g].found);
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= '0;
      pol_q      <= LINE_MASK;
      sticky_q   <= '0;
      raw_prev_q <= '0;
      edges_q    <= '0;
      pend_q     <= '0;
      en_q       <= '0;
      lim_q      <= {LIMIT_RESET, LIMIT_RESET};
      sav_q      <= '0;
      prio_q     <= '0;
      irq_q      <= '0;
    end else begin
      active_q   <= active_d;
      pol_q      <= pol_d;
      sticky_q   <= sticky_d;
      raw_prev_q <= raw_prev_d;
      edges_q    <= edges_d;
      pend_q     <= pend_d;
      en_q       <= en_d;
      lim_q      <= lim_d;
      sav_q      <= sav_d;
      prio_q     <= prio_d;
      irq_q      <= irq_d;
    end
  end

  assign rsp_o.read_data   = rd;
  assign rsp_o.bad_access  = bad;
  assign rsp_o.irq_request = irq_d[0];
  assign rsp_o.fiq_request = irq_d[1];

endmodule

[design/priority_interrupt_controller.sv]
// Priority interrupt controller, 32 source lines, IRQ and FIQ outputs.
// Request channel (req_valid_i / req_ready_o / req_i): each request is a
// register read, a register write or a change of level on one source line.
// Response channel (rsp_valid_o / rsp_ready_i / rsp_o): exactly one
// response per request, in order, carrying the read data, the bad access
// flag and the IRQ and FIQ request levels after that request.
// Flow: an accepted request enters the input register, and its response is
// loaded into the response register once that one is free or being emptied.
// Throughput: one request per cycle while each response is taken at once;
// decode, state update and the 32-way priority compare trees all sit
// between the input register and the response register.
// Reset: all line setup, masks, priorities and requests return to their
// reset values (limits 8, polarity active high); both channels empty.
// Stall: while a response waits unaccepted the input register still takes
// one more request; once both are full req_ready_o drops until the
// receiver takes the response. Nothing is lost or repeated.
module priority_interrupt_controller (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  pic_pkg::pic_req_t req_i,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output pic_pkg::pic_rsp_t rsp_o
);
  import pic_pkg::*;

  logic     in_valid_q;
  pic_req_t in_q;
  logic     out_valid_q;
  pic_rsp_t out_q;
  logic     advance;
  pic_rsp_t rsp_next;

  // request moves on when the response slot is free or being emptied
  assign advance     = in_valid_q && (!out_valid_q || rsp_ready_i);
  assign req_ready_o = !in_valid_q || advance;

  pic_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .req_i  (in_q),
    .rsp_o  (rsp_next)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_valid_i && req_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i && req_ready_o) begin
      in_q <= req_i;
    end
  end

  // response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= rsp_next;
    end
  end

  assign rsp_valid_o = out_valid_q;
  assign rsp_o       = out_q;

endmodule
